@@ rtl/rhps_pkg.sv @@
`default_nettype none
package rhps_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 12;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AIRLIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HAZE_DENSITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd4;

  localparam logic [8:0]  AIRLIGHT_RST     = 9'd128;
  localparam logic [15:0] HAZE_DENSITY_RST = 16'd1311;
  localparam logic [7:0]  DEPTH_OFFSET_RST = 8'd45;
  localparam int          CENTER_X_RST     = 320;
  localparam int          CENTER_Y_RST     = 240;

  // fixed-point constants
  localparam logic [11:0] K_004     = 12'd2621;       // 0.04 in Q.16
  localparam logic [17:0] K_LOG2E   = 18'd94548;      // log2(e) in Q.16
  localparam logic [29:0] K_LN2_Q30 = 30'd744261118;  // ln2 in Q.30
  localparam logic [17:0] T_MAX     = 18'h3FFFF;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam int          TAYLOR_N  = 10;

  localparam int RGB_W       = 24;
  localparam int OUT_TDATA_W = 48;

  // floor(2^32 / k), k = 1..10
  localparam logic [32:0] RECIP [1:10] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729
  };

  // bus between the exp2 series stages
  typedef struct packed {
    logic [30:0]      term;
    logic [29:0]      z;
    logic [31:0]      sum;
    logic [4:0]       sh;    // final right shift, 13..31
    logic             sat;   // transmission saturates high
    logic             zero;  // transmission underflows to 0
    logic [RGB_W-1:0] rgb;
  } tay_t;

endpackage
`default_nettype wire

@@ rtl/radial_haze_pixel_synth.sv @@
`default_nettype none
// Radial haze synthesis: each beat on the input stream carries one clear RGB
// pixel and its column/row; the block adds haze by the scattering model
// out = p*t + 255*A*(1-t), with t = exp(-beta*(offset - 0.04*r)) and r the
// Euclidean distance to the configured center, and returns the hazy pixel
// plus t (unsigned Q2.16, saturated). The datapath is a fully pipelined
// chain: distance (3 stages), square root one bit per stage (COORD_BITS+9
// stages), depth and base-2 exponent split (7 stages), ten Taylor terms of
// 2^f (3 stages each) and the mix (3 stages). One pixel enters per clock
// while the output is not stalled; the whole pipe holds only when a result
// sits on the output and is not taken. The user must write registers through
// cfg_* between frames, while no pixel is in flight; the block does not enforce this.
module radial_haze_pixel_synth #(
  parameter int COORD_BITS = rhps_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // pos_x, pos_y, red_in, green_in, blue_in (from bit 0), zero fill
  input  wire logic [((2*COORD_BITS+24+7)/8)*8-1:0] in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // red_out, green_out, blue_out, transmission (from bit 0), zero fill
  output logic [rhps_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_we,
  input  wire logic [rhps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rhps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rhps_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int ROOT_W = (2*CB + 18) / 2;

  // configuration registers
  logic [8:0]    airlight_r;
  logic [15:0]   haze_density_r;
  logic [7:0]    depth_offset_r;
  logic [CB-1:0] center_x_r, center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      airlight_r     <= AIRLIGHT_RST;
      haze_density_r <= HAZE_DENSITY_RST;
      depth_offset_r <= DEPTH_OFFSET_RST;
      center_x_r     <= CB'(CENTER_X_RST);
      center_y_r     <= CB'(CENTER_Y_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AIRLIGHT:     airlight_r     <= cfg_data[8:0];
        REG_HAZE_DENSITY: haze_density_r <= cfg_data;
        REG_DEPTH_OFFSET: depth_offset_r <= cfg_data[7:0];
        REG_CENTER_X:     center_x_r     <= cfg_data[CB-1:0];
        REG_CENTER_Y:     center_y_r     <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // single pipeline enable: advance unless the output beat is stalled
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                 in_beat;
  assign in_beat = in_tvalid && in_tready;

  // distance squared
  logic                 dist_v;
  logic [2*CB:0]        d2;
  logic [RGB_W-1:0]     dist_rgb;

  rhps_dist #(.CB(CB)) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_beat),
    .pos_x    (in_tdata[CB-1:0]),
    .pos_y    (in_tdata[2*CB-1:CB]),
    .cx       (center_x_r),
    .cy       (center_y_r),
    .rgb_in   (in_tdata[2*CB+23:2*CB]),
    .out_valid(dist_v),
    .d2       (d2),
    .rgb_out  (dist_rgb)
  );

  // r in Q.8
  logic                 sq_v;
  logic [ROOT_W-1:0]    r8;
  logic [RGB_W-1:0]     sq_rgb;

  rhps_isqrt #(.CB(CB)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dist_v),
    .d2       (d2),
    .rgb_in   (dist_rgb),
    .out_valid(sq_v),
    .root     (r8),
    .rgb_out  (sq_rgb)
  );

  // depth, beta*d, exponent split
  logic                 tay_v [TAYLOR_N+1];
  tay_t                 tay_bus [TAYLOR_N+1];

  rhps_expo #(.ROOT_W(ROOT_W)) u_expo (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (sq_v),
    .r8           (r8),
    .rgb_in       (sq_rgb),
    .haze_density (haze_density_r),
    .depth_offset (depth_offset_r),
    .out_valid    (tay_v[0]),
    .out_bus      (tay_bus[0])
  );

  // 2^f by Taylor series, one term per block
  for (genvar k = 1; k <= TAYLOR_N; k++) begin : g_term
    rhps_term #(.K(k)) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (tay_v[k-1]),
      .in_bus   (tay_bus[k-1]),
      .out_valid(tay_v[k]),
      .out_bus  (tay_bus[k])
    );
  end

  // transmission and channel mix, ends in the output register
  logic [7:0]  red_o, green_o, blue_o;
  logic [17:0] trans_o;

  rhps_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (tay_v[TAYLOR_N]),
    .in_bus   (tay_bus[TAYLOR_N]),
    .airlight (airlight_r),
    .out_valid(out_tvalid),
    .red      (red_o),
    .green    (green_o),
    .blue     (blue_o),
    .trans    (trans_o)
  );

  assign out_tdata = {6'b0, trans_o, blue_o, green_o, red_o};

endmodule
`default_nettype wire

@@ rtl/rhps_dist.sv @@
`default_nettype none
module rhps_dist #(
  parameter int CB = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [CB-1:0]           pos_x,
  input  wire logic [CB-1:0]           pos_y,
  input  wire logic [CB-1:0]           cx,
  input  wire logic [CB-1:0]           cy,
  input  wire logic [rhps_pkg::RGB_W-1:0] rgb_in,
  output logic                         out_valid,
  output logic [2*CB:0]                d2,
  output logic [rhps_pkg::RGB_W-1:0]   rgb_out
);
  import rhps_pkg::*;

  logic [2:0]              v_r;
  logic signed [CB:0]      dx_r, dy_r;
  logic signed [2*CB+1:0]  sqx_full, sqy_full;
  logic [2*CB-1:0]         sqx_r, sqy_r;
  logic [2*CB:0]           d2_r;
  logic [RGB_W-1:0]        rgb1_r, rgb2_r, rgb3_r;

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= $signed({1'b0, pos_x}) - $signed({1'b0, cx});
      dy_r   <= $signed({1'b0, pos_y}) - $signed({1'b0, cy});
      rgb1_r <= rgb_in;
      sqx_r  <= sqx_full[2*CB-1:0];
      sqy_r  <= sqy_full[2*CB-1:0];
      rgb2_r <= rgb1_r;
      d2_r   <= (2*CB+1)'(sqx_r) + (2*CB+1)'(sqy_r);
      rgb3_r <= rgb2_r;
    end
  end

  assign out_valid = v_r[2];
  assign d2        = d2_r;
  assign rgb_out   = rgb3_r;

endmodule
`default_nettype wire

@@ rtl/rhps_isqrt.sv @@
`default_nettype none
module rhps_isqrt #(
  parameter int CB = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [2*CB:0]               d2,
  input  wire logic [rhps_pkg::RGB_W-1:0]  rgb_in,
  output logic                             out_valid,
  output logic [(2*CB+18)/2-1:0]           root,
  output logic [rhps_pkg::RGB_W-1:0]       rgb_out
);
  import rhps_pkg::*;

  localparam int RAD_W  = 2*CB + 17;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int RW     = ROOT_W + 2;

  // one result bit per stage, restoring recurrence
  logic [2*ROOT_W-1:0] rad_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [RW-1:0]       rem_r  [ROOT_W];
  logic [RGB_W-1:0]    rgb_r  [ROOT_W];
  logic [ROOT_W-1:0]   v_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [2*ROOT_W-1:0] rad_in;
    logic [ROOT_W-1:0]   root_in;
    logic [RW-1:0]       rem_in;
    logic [RGB_W-1:0]    rgb_i;
    logic                v_i;
    logic [RW+1:0]       rem_sh, trial;

    if (i == 0) begin : g_first
      assign rad_in  = (2*ROOT_W)'({d2, 16'h0});
      assign root_in = '0;
      assign rem_in  = '0;
      assign rgb_i   = rgb_in;
      assign v_i     = in_valid;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign root_in = root_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign rgb_i   = rgb_r[i-1];
      assign v_i     = v_r[i-1];
    end

    assign rem_sh = {rem_in, rad_in[2*(ROOT_W-1-i)+1 -: 2]};
    assign trial  = (RW+2)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[i]  <= RW'(rem_sh - trial);
          root_r[i] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[i]  <= RW'(rem_sh);
          root_r[i] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_r[i] <= rad_in;
        rgb_r[i] <= rgb_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];
  assign rgb_out   = rgb_r[ROOT_W-1];

endmodule
`default_nettype wire

@@ rtl/rhps_expo.sv @@
`default_nettype none
module rhps_expo #(
  parameter int ROOT_W = 21
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [ROOT_W-1:0]           r8,
  input  wire logic [rhps_pkg::RGB_W-1:0]  rgb_in,
  input  wire logic [15:0]                 haze_density,
  input  wire logic [7:0]                  depth_offset,
  output logic                             out_valid,
  output rhps_pkg::tay_t                   out_bus
);
  import rhps_pkg::*;

  localparam int G_W = ROOT_W + 5;
  localparam int D_W = ((G_W > 24) ? G_W : 24) + 1;
  localparam int X_W = D_W + 17;   // beta * d product
  localparam int Y_W = D_W + 19;   // x * log2e product
  localparam int N_W = D_W - 12;   // integer part of -y

  logic [6:0]              v_r;
  logic [RGB_W-1:0]        rgb_r [7];

  logic [ROOT_W+11:0]      gp_r;
  logic [ROOT_W+12:0]      g_sum;
  logic [G_W-1:0]          g16;
  logic signed [D_W-1:0]   d16_r;
  logic signed [X_W-1:0]   xp_r, x_rnd;
  logic signed [D_W:0]     x16_r;
  logic signed [Y_W-1:0]   yp_r, y_rnd;
  logic signed [D_W+2:0]   y16;
  logic signed [D_W+3:0]   s;
  logic signed [N_W-1:0]   n;
  logic [15:0]             f_r;
  logic [4:0]              sh_r, sh6_r;
  logic                    sat_r, zero_r, sat6_r, zero6_r;
  logic [45:0]             zp;
  logic [29:0]             z_r;

  assign g_sum = (ROOT_W+13)'(gp_r) + (ROOT_W+13)'(128);
  assign g16   = g_sum[ROOT_W+12:8];
  assign x_rnd = xp_r + $signed(X_W'(32768));
  assign y_rnd = yp_r + $signed(Y_W'(32768));
  assign y16   = y_rnd[Y_W-1:16];
  assign s     = -$signed({y16[D_W+2], y16});
  assign n     = s[D_W+3:16];
  assign zp    = f_r * K_LN2_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // 0.04 * r
      gp_r     <= r8 * K_004;
      rgb_r[0] <= rgb_in;
      // depth in Q.16
      d16_r    <= $signed(D_W'({depth_offset, 16'h0})) - $signed(D_W'(g16));
      rgb_r[1] <= rgb_r[0];
      // beta * d
      xp_r     <= $signed({1'b0, haze_density}) * d16_r;
      rgb_r[2] <= rgb_r[1];
      x16_r    <= x_rnd[X_W-1:16];
      rgb_r[3] <= rgb_r[2];
      // convert to base 2
      yp_r     <= x16_r * $signed(K_LOG2E);
      rgb_r[4] <= rgb_r[3];
      // split exponent into integer and fraction
      f_r      <= s[15:0];
      sat_r    <= (n >= N_W'(2));
      zero_r   <= (n <= N_W'(-18));
      sh_r     <= 5'(N_W'(14) - n);
      rgb_r[5] <= rgb_r[4];
      // fraction times ln2, Q.30
      z_r      <= zp[45:16];
      sh6_r    <= sh_r;
      sat6_r   <= sat_r;
      zero6_r  <= zero_r;
      rgb_r[6] <= rgb_r[5];
    end
  end

  assign out_valid     = v_r[6];
  assign out_bus.term  = ONE_Q30;
  assign out_bus.z     = z_r;
  assign out_bus.sum   = 32'(ONE_Q30);
  assign out_bus.sh    = sh6_r;
  assign out_bus.sat   = sat6_r;
  assign out_bus.zero  = zero6_r;
  assign out_bus.rgb   = rgb_r[6];

endmodule
`default_nettype wire

@@ rtl/rhps_term.sv @@
`default_nettype none
module rhps_term #(
  parameter int K = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  rhps_pkg::tay_t      in_bus,
  output logic                out_valid,
  output rhps_pkg::tay_t      out_bus
);
  import rhps_pkg::*;

  // term_k = ((term_{k-1} * z) >> 30) / K, divide by reciprocal plus one fixup
  logic [2:0]  v_r;
  tay_t        bus_a_r, bus_b_r, bus_c_r;
  tay_t        bus_c_nxt;
  logic [60:0] prod_r;
  logic [30:0] u, u_r, q0_r, rem, q;
  logic [63:0] qp;
  logic [34:0] qk;

  assign u   = prod_r[60:30];
  assign qp  = u * RECIP[K];
  assign qk  = q0_r * 4'(K);
  assign rem = u_r - qk[30:0];
  assign q   = (rem >= 31'(K)) ? q0_r + 31'd1 : q0_r;

  always_comb begin
    bus_c_nxt      = bus_b_r;
    bus_c_nxt.term = q;
    bus_c_nxt.sum  = bus_b_r.sum + 32'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= in_bus.term * in_bus.z;
      bus_a_r <= in_bus;
      u_r     <= u;
      q0_r    <= qp[62:32];
      bus_b_r <= bus_a_r;
      bus_c_r <= bus_c_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign out_bus   = bus_c_r;

endmodule
`default_nettype wire

@@ rtl/rhps_mix.sv @@
`default_nettype none
module rhps_mix (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  rhps_pkg::tay_t      in_bus,
  input  wire logic [8:0]     airlight,
  output logic                out_valid,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [17:0]         trans
);
  import rhps_pkg::*;

  logic [2:0]          v_r;
  logic [32:0]         rnd, shv;
  logic [17:0]         t_r, t2_r, t3_r;
  logic [RGB_W-1:0]    rgb_r;
  logic [16:0]         a255;
  logic signed [19:0]  dt;
  logic [25:0]         pt_r [3];
  logic signed [37:0]  at_r;
  logic [7:0]          chan [3];

  // round and scale 2^(f) down by 2^(14-n)
  assign rnd  = 33'(in_bus.sum) + (33'd1 << (in_bus.sh - 5'd1));
  assign shv  = rnd >> in_bus.sh;
  assign a255 = {airlight, 8'h0} - 17'(airlight);
  assign dt   = $signed(20'd65536) - $signed({2'b0, t_r});

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [38:0] num;
    logic signed [14:0] cv;
    assign num = $signed({5'b0, pt_r[c], 8'h0}) + at_r + $signed(39'd8388608);
    assign cv  = num[38:24];
    always_comb begin
      if (num[38]) begin
        chan[c] = 8'h00;
      end else if (|cv[14:8]) begin
        chan[c] = 8'hFF;
      end else begin
        chan[c] = cv[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_bus.sat) begin
        t_r <= T_MAX;
      end else if (in_bus.zero) begin
        t_r <= '0;
      end else if (shv > 33'(T_MAX)) begin
        t_r <= T_MAX;
      end else begin
        t_r <= shv[17:0];
      end
      rgb_r   <= in_bus.rgb;
      pt_r[0] <= rgb_r[7:0]   * t_r;
      pt_r[1] <= rgb_r[15:8]  * t_r;
      pt_r[2] <= rgb_r[23:16] * t_r;
      at_r    <= $signed({1'b0, a255}) * dt;
      t2_r    <= t_r;
      red     <= chan[0];
      green   <= chan[1];
      blue    <= chan[2];
      t3_r    <= t2_r;
    end
  end

  assign out_valid = v_r[2];
  assign trans     = t3_r;

endmodule
`default_nettype wire

@@ rtl/rhps_check.sv @@
`default_nettype none
module rhps_check (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [rhps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);
  import rhps_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // a stalled output freezes the pipe, so no input is taken
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // with no result waiting the pipe always takes a beat
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready with empty output");

  // fill bits above the transmission stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:42] == '0)
    else $error("nonzero fill bits in output beat");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind radial_haze_pixel_synth rhps_check u_rhps_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
  import rhps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = 12;
  localparam int IN_W      = ((2*CB+24+7)/8)*8;
  localparam int LATENCY   = CB + 52;
  localparam int LIMIT     = 400000;
  localparam int N_PHASES  = 12;
  localparam int PER_PHASE = 130;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  radial_haze_pixel_synth #(.COORD_BITS(CB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [17:0] trans;
  } hazy_t;

  typedef struct {
    int          ph;      // config set for this row
    logic [11:0] x, y;
    logic [7:0]  r, g, b;
    bit          typed;   // expected value given in the row
    hazy_t       res;
  } row_t;

  // shadow registers
  logic [8:0]    sh_air;
  logic [15:0]   sh_beta;
  logic [7:0]    sh_ofs;
  logic [CB-1:0] sh_cx, sh_cy;

  hazy_t hazy_q[$];
  int    n_err = 0;
  int    snd_idle = 38, rcv_idle = 38;
  longint unsigned cyc = 0;

  // ---------------------------------------------------------------------
  // predictor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0, bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // 2^(f/65536) in Q.30, ten Taylor terms of exp(f*ln2)
  function automatic longint unsigned pow2_frac(longint unsigned f);
    longint unsigned z = (f * 64'd744261118) >> 16;
    longint unsigned term = 64'd1 << 30;
    longint unsigned acc = term;
    for (int k = 1; k <= 10; k++) begin
      term = (term * z) >> 30;
      term = term / k;
      acc += term;
    end
    return acc;
  endfunction

  function automatic logic [7:0] blend(longint unsigned p, longint unsigned t);
    longint c;
    c = longint'(p * t * 256) + longint'(255 * longint'(sh_air)) * (65536 - longint'(t));
    c = (c + (longint'(1) << 23)) >>> 24;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c[7:0];
  endfunction

  function automatic hazy_t haze_pixel(logic [IN_W-1:0] d);
    longint dx, dy, d16, x16, y16, s, n;
    longint unsigned r8, g16, t, m, f;
    int sh;
    hazy_t h;
    dx = longint'(d[CB-1:0]) - longint'(sh_cx);
    dy = longint'(d[2*CB-1:CB]) - longint'(sh_cy);
    r8 = int_sqrt(longint'(dx*dx + dy*dy) << 16);
    g16 = (r8 * 2621 + 128) >> 8;
    d16 = (longint'(sh_ofs) << 16) - longint'(g16);
    x16 = (longint'(sh_beta) * d16 + 32768) >>> 16;
    y16 = (x16 * 94548 + 32768) >>> 16;
    s = -y16;
    n = s >>> 16;
    f = s & 64'hFFFF;
    if (n >= 2) begin
      t = 262143;
    end else if (14 - n > 62) begin
      t = 0;
    end else begin
      sh = 14 - n;
      m = pow2_frac(f);
      t = (m + (64'd1 << (sh - 1))) >> sh;
      if (t > 262143) t = 262143;
    end
    h.red   = blend(d[2*CB+7:2*CB], t);
    h.green = blend(d[2*CB+15:2*CB+8], t);
    h.blue  = blend(d[2*CB+23:2*CB+16], t);
    h.trans = t[17:0];
    return h;
  endfunction

  // ---------------------------------------------------------------------
  // config writes, only when nothing is in flight
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_AIRLIGHT:     sh_air  = val[8:0];
      REG_HAZE_DENSITY: sh_beta = val;
      REG_DEPTH_OFFSET: sh_ofs  = val[7:0];
      REG_CENTER_X:     sh_cx   = val[CB-1:0];
      REG_CENTER_Y:     sh_cy   = val[CB-1:0];
      default: ;  // ignored by the block
    endcase
  endtask

  task automatic drain();
    while (hazy_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic load_regs(logic [8:0] a, logic [15:0] bt, logic [7:0] o,
                           logic [11:0] cx, logic [11:0] cy);
    drain();
    reg_write(REG_AIRLIGHT, {7'(0), a});
    reg_write(REG_HAZE_DENSITY, bt);
    reg_write(REG_DEPTH_OFFSET, {8'(0), o});
    reg_write(REG_CENTER_X, {4'(0), cx});
    reg_write(REG_CENTER_Y, {4'(0), cy});
    cfg_we <= 1'b0;
  endtask

  // one pixel beat; holds tvalid across back-to-back beats
  task automatic send_pixel(logic [IN_W-1:0] d, bit typed, hazy_t res);
    if ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    hazy_q.insert(hazy_q.size(), typed ? res : haze_pixel(d));
  endtask

  function automatic logic [IN_W-1:0] pack_px(logic [11:0] x, logic [11:0] y,
                                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return IN_W'({b, g, r, y, x});
  endfunction

  function automatic logic [11:0] pick12();
    case ($urandom_range(5))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // result checker and ready pattern
  always @(posedge clk) begin
    hazy_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.red   = out_tdata[7:0];
      got.green = out_tdata[15:8];
      got.blue  = out_tdata[23:16];
      got.trans = out_tdata[41:24];
      if (hazy_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected beat %h", out_tdata);
      end else begin
        want = hazy_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch exp r%0d g%0d b%0d t%0d got r%0d g%0d b%0d t%0d",
                     want.red, want.green, want.blue, want.trans,
                     got.red, got.green, got.blue, got.trans);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // directed rows; the hd=0 set leaves pixels untouched with t = 1.0
  localparam hazy_t NONE = '0;
  row_t rows[] = '{
    '{0, 12'd320, 12'd240, 8'd0,   8'd128, 8'd255, 0, NONE},
    '{0, 12'd0,   12'd0,   8'd255, 8'd255, 8'd255, 0, NONE},
    '{0, 12'hFFF, 12'hFFF, 8'd0,   8'd0,   8'd0,   0, NONE},
    '{0, 12'd100, 12'd400, 8'd17,  8'd200, 8'd90,  0, NONE},
    '{1, 12'd0,   12'd0,   8'd0,   8'd0,   8'd0,   1, '{8'd0, 8'd0, 8'd0, 18'd65536}},
    '{1, 12'hFFF, 12'hFFF, 8'd255, 8'd255, 8'd255, 1, '{8'd255, 8'd255, 8'd255, 18'd65536}},
    '{1, 12'd320, 12'd240, 8'd170, 8'd85,  8'd1,   1, '{8'd170, 8'd85, 8'd1, 18'd65536}},
    '{2, 12'hFFF, 12'd0,   8'd10,  8'd20,  8'd30,  0, NONE},
    '{2, 12'd0,   12'hFFF, 8'd255, 8'd0,   8'd255, 0, NONE},
    '{2, 12'd4000, 12'd50, 8'd0,   8'd255, 8'd0,   0, NONE},
    '{3, 12'd0,   12'hFFF, 8'd255, 8'd255, 8'd255, 0, NONE},
    '{3, 12'hFFF, 12'd0,   8'd0,   8'd0,   8'd0,   0, NONE},
    '{3, 12'd0,   12'd4095, 8'd77, 8'd66,  8'd55,  0, NONE},
    '{4, 12'd77,  12'd99,  8'd200, 8'd100, 8'd50,  1, '{8'd200, 8'd100, 8'd50, 18'd65536}},
    '{4, 12'd77,  12'd99,  8'd0,   8'd255, 8'd9,   1, '{8'd0, 8'd255, 8'd9, 18'd65536}},
    '{5, 12'd2048, 12'd2048, 8'd0, 8'd128, 8'd255, 0, NONE},
    '{5, 12'd0,   12'd0,   8'd255, 8'd1,   8'd254, 0, NONE}
  };

  task automatic set_phase(int ph);
    case (ph)
      0: ;  // reset values
      1: load_regs(9'd128, 16'd0, 8'd45, 12'd320, 12'd240);
      2: load_regs(9'd511, 16'hFFFF, 8'd255, 12'hFFF, 12'd0);
      3: load_regs(9'd0, 16'hFFFF, 8'd0, 12'd0, 12'hFFF);
      // at the center with zero depth offset, t is exactly 1.0
      4: load_regs(9'd256, 16'd40000, 8'd0, 12'd77, 12'd99);
      5: load_regs(9'd256, 16'd3000, 8'd120, 12'd2048, 12'd2048);
      default: ;
    endcase
  endtask

  initial begin
    int cur;
    logic [11:0] px, py;
    sh_air  = AIRLIGHT_RST;
    sh_beta = HAZE_DENSITY_RST;
    sh_ofs  = DEPTH_OFFSET_RST;
    sh_cx   = CB'(CENTER_X_RST);
    sh_cy   = CB'(CENTER_Y_RST);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].ph != cur) begin
        in_tvalid <= 1'b0;
        cur = rows[i].ph;
        set_phase(cur);
      end
      send_pixel(pack_px(rows[i].x, rows[i].y, rows[i].r, rows[i].g, rows[i].b),
                 rows[i].typed, rows[i].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      logic [8:0]  a;
      logic [15:0] bt;
      logic [7:0]  o;
      in_tvalid <= 1'b0;
      case ($urandom_range(3))
        0: a = 9'd0; 1: a = 9'd256; 2: a = 9'h1FF; default: a = 9'($urandom);
      endcase
      case ($urandom_range(4))
        0: bt = 16'd0; 1: bt = 16'hFFFF; 2: bt = 16'($urandom);
        default: bt = 16'($urandom_range(4000));
      endcase
      case ($urandom_range(3))
        0: o = 8'd0; 1: o = 8'hFF; default: o = 8'($urandom);
      endcase
      load_regs(a, bt, o, pick12(), pick12());
      if (p == 3) begin
        // stray writes to unused indexes must change nothing
        @(posedge clk);
        reg_write(CFG_IDX_W'(5), 16'($urandom));
        reg_write(CFG_IDX_W'(7), 16'($urandom));
        cfg_we <= 1'b0;
      end
      snd_idle = (p == 5) ? 0 : 38;
      rcv_idle = (p == 5) ? 0 : 38;
      for (int k = 0; k < PER_PHASE; k++) begin
        if (p == 2 && k == 60) begin
          in_tvalid <= 1'b0;
          while (hazy_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(1)) begin
          px = 12'(sh_cx + $urandom_range(300) - 150);
          py = 12'(sh_cy + $urandom_range(300) - 150);
        end else begin
          px = pick12();
          py = pick12();
        end
        send_pixel(pack_px(px, py, 8'($urandom), 8'($urandom), 8'($urandom)), 0, NONE);
      end
    end
    in_tvalid <= 1'b0;
    rcv_idle = 38;
    drain();
    if (n_err == 0 && hazy_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
